// File: hdl/ookpw_pkg.sv
// Shared types, codes and constants of the pulse-width decoder.
package ookpw_pkg;

    // Command codes carried in tuser
    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_PIN  = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;
    localparam logic [1:0] CMD_NOP  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_SYNC_TH  = 2'd0;
    localparam logic [1:0] CFG_LONG_TH  = 2'd1;
    localparam logic [1:0] CFG_MIN_BITS = 2'd2;
    localparam logic [1:0] CFG_MAX_BITS = 2'd3;

    localparam int TIMER_W = 8;
    localparam int COUNT_W = 6;
    localparam int WORD_W  = 32;
    localparam int CFG_W   = 8;

    localparam logic [TIMER_W-1:0] TIMER_TOP    = 8'd255;
    localparam logic [COUNT_W-1:0] WORD_BITS    = 6'd32;
    localparam logic [7:0]         RST_SYNC_TH  = 8'd24;
    localparam logic [7:0]         RST_LONG_TH  = 8'd5;
    localparam logic [COUNT_W-1:0] RST_MIN_BITS = 6'd24;
    localparam logic [COUNT_W-1:0] RST_MAX_BITS = 6'd32;

    // Classified operation passed from front to back
    typedef struct packed {
        logic [1:0] cmd;
        logic       level;
    } t_op;

    // One result item
    typedef struct packed {
        logic [COUNT_W-1:0] bits_received;
        logic               frame_latched;
        logic [WORD_W-1:0]  read_data;
    } t_result;

endpackage

// File: hdl/ookpw_front.sv
// Front end: accepts input transactions and classifies them into operations.
module ookpw_front (
    input  logic              i_s_valid,
    output logic              o_s_ready,
    input  logic [1:0]        i_cmd,
    input  logic              i_level,
    input  logic              i_q_ready,
    output logic              o_q_push,
    output ookpw_pkg::t_op    o_q_op
);

    // Accept whenever the queue has room
    assign o_s_ready = i_q_ready;
    assign o_q_push  = i_s_valid & i_q_ready;

    // Classify: keep the level only for a pin change
    always_comb begin
        o_q_op.cmd   = i_cmd;
        o_q_op.level = 1'b0;
        unique case (i_cmd)
            ookpw_pkg::CMD_PIN: begin
                o_q_op.level = i_level;
            end
            ookpw_pkg::CMD_TICK, ookpw_pkg::CMD_READ, ookpw_pkg::CMD_NOP: begin
                o_q_op.level = 1'b0;
            end
            default: begin
                o_q_op.level = 1'b0;
            end
        endcase
    end

endmodule

// File: hdl/ookpw_queue.sv
// Two-entry operation queue between the front and back ends.
module ookpw_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ookpw_pkg::t_op    i_op,
    output logic              o_ready,
    input  logic              i_pop,
    output logic              o_valid,
    output ookpw_pkg::t_op    o_op
);

    ookpw_pkg::t_op r_mem [2];
    logic           r_wptr;
    logic           r_rptr;
    logic [1:0]     r_count;
    logic [1:0]     n_count;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_op    = r_mem[r_rptr];

    // Track occupancy
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
        end
    end

    // Store payload
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_op;
        end
    end

endmodule

// File: hdl/ookpw_back.sv
// Back end: decoder state, configuration registers and the result register.
module ookpw_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [1:0]                      i_cfg_idx,
    input  logic [ookpw_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                            i_q_valid,
    input  ookpw_pkg::t_op                  i_q_op,
    output logic                            o_q_pop,
    output logic                            o_valid,
    input  logic                            i_ready,
    output ookpw_pkg::t_result              o_result
);

    localparam int TW = ookpw_pkg::TIMER_W;
    localparam int CW = ookpw_pkg::COUNT_W;
    localparam int WW = ookpw_pkg::WORD_W;

    // Configuration
    logic [TW-1:0] r_sync_th;
    logic [TW-1:0] r_long_th;
    logic [CW-1:0] r_min_bits;
    logic [CW-1:0] r_max_bits;

    // Decoder state
    logic [TW-1:0] r_timer,   n_timer;
    logic          r_running, n_running;
    logic [TW-1:0] r_high,    n_high;
    logic [WW-1:0] r_shift,   n_shift;
    logic [CW-1:0] r_count,   n_count;
    logic          r_invalid, n_invalid;
    logic [WW-1:0] r_latch,   n_latch;

    // Result register
    logic               r_out_valid;
    ookpw_pkg::t_result r_out;
    ookpw_pkg::t_result n_out;

    logic [CW-1:0] w_limit;
    logic          w_high_long;
    logic          w_low_long;

    assign o_q_pop  = i_q_valid & (~r_out_valid | i_ready);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    assign w_limit     = (r_max_bits > ookpw_pkg::WORD_BITS) ? ookpw_pkg::WORD_BITS
                                                            : r_max_bits;
    assign w_high_long = (r_high > r_long_th);
    assign w_low_long  = (r_timer > r_long_th);

    // Work out the next state and the result of the head operation
    always_comb begin
        n_timer   = r_timer;
        n_running = r_running;
        n_high    = r_high;
        n_shift   = r_shift;
        n_count   = r_count;
        n_invalid = r_invalid;
        n_latch   = r_latch;
        n_out.read_data     = '0;
        n_out.frame_latched = 1'b0;
        unique case (i_q_op.cmd)
            ookpw_pkg::CMD_TICK: begin
                if (r_running) begin
                    if (r_timer == ookpw_pkg::TIMER_TOP) begin
                        n_timer   = '0;
                        n_running = 1'b0;
                    end else begin
                        n_timer = r_timer + TW'(1);
                    end
                end
            end
            ookpw_pkg::CMD_PIN: begin
                n_timer   = '0;
                n_running = 1'b1;
                if (!i_q_op.level) begin
                    n_high = r_timer;
                end else if (r_timer > r_sync_th) begin
                    // Sync gap: latch a well-formed frame, then start afresh
                    if (!r_invalid && (r_count >= r_min_bits) && (r_count <= w_limit)) begin
                        n_latch             = r_shift;
                        n_out.frame_latched = 1'b1;
                    end
                    n_shift   = '0;
                    n_count   = '0;
                    n_invalid = 1'b0;
                end else if (!r_invalid && (r_count < w_limit)) begin
                    // Data bit from the high/low phase pair
                    if (w_high_long == w_low_long) begin
                        n_invalid = 1'b1;
                        n_count   = '0;
                    end else begin
                        n_shift = {r_shift[WW-2:0], w_high_long};
                        n_count = r_count + CW'(1);
                    end
                end
            end
            ookpw_pkg::CMD_READ: begin
                n_out.read_data = r_latch;
                n_latch         = '0;
            end
            ookpw_pkg::CMD_NOP: begin
                n_out.read_data = '0;
            end
            default: begin
                n_out.read_data = '0;
            end
        endcase
        n_out.bits_received = n_count;
    end

    // Hold configuration; writes must arrive only while idle, which the block does not enforce
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_th  <= ookpw_pkg::RST_SYNC_TH;
            r_long_th  <= ookpw_pkg::RST_LONG_TH;
            r_min_bits <= ookpw_pkg::RST_MIN_BITS;
            r_max_bits <= ookpw_pkg::RST_MAX_BITS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ookpw_pkg::CFG_SYNC_TH:  r_sync_th  <= i_cfg_data;
                ookpw_pkg::CFG_LONG_TH:  r_long_th  <= i_cfg_data;
                ookpw_pkg::CFG_MIN_BITS: r_min_bits <= i_cfg_data[CW-1:0];
                ookpw_pkg::CFG_MAX_BITS: r_max_bits <= i_cfg_data[CW-1:0];
                default: begin
                end
            endcase
        end
    end

    // Advance decoder state on each popped operation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer     <= '0;
            r_running   <= 1'b0;
            r_high      <= '0;
            r_shift     <= '0;
            r_count     <= '0;
            r_invalid   <= 1'b1;
            r_latch     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_timer   <= n_timer;
                r_running <= n_running;
                r_high    <= n_high;
                r_shift   <= n_shift;
                r_count   <= n_count;
                r_invalid <= n_invalid;
                r_latch   <= n_latch;
            end
            if (o_q_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Load the result payload
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_out <= n_out;
        end
    end

endmodule

// File: hdl/ook_pulse_width_decoder_unit.sv
// An accepted transaction is registered in the queue; once the back end pops it,
// its result is registered and offered on the output; the pop waits while a result is
// held untaken. Throughput: one transaction per cycle unless the output stalls.
// A two-entry queue parts input from the result register, so either side may stall.
// Reset (synchronous, active low) restores default thresholds, stops the timer,
// clears the frame state and marks the frame invalid until the first sync.
module ook_pulse_width_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] level, [7:1] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // [31:0] read_data, [32] frame_latched,
                                        // [38:33] bits_received, [39] zero
);

    logic               w_q_ready;
    logic               w_q_push;
    ookpw_pkg::t_op     w_push_op;
    logic               w_q_valid;
    logic               w_q_pop;
    ookpw_pkg::t_op     w_head_op;
    ookpw_pkg::t_result w_result;

    // Accept and classify
    ookpw_front u_front (
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_cmd     (s_axis_tuser),
        .i_level   (s_axis_tdata[0]),
        .i_q_ready (w_q_ready),
        .o_q_push  (w_q_push),
        .o_q_op    (w_push_op)
    );

    // Buffer operations
    ookpw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_op    (w_push_op),
        .o_ready (w_q_ready),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_op    (w_head_op)
    );

    // Execute and present results
    ookpw_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_valid  (w_q_valid),
        .i_q_op     (w_head_op),
        .o_q_pop    (w_q_pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_result   (w_result)
    );

    // Pack result fields under a zero top bit
    assign m_axis_tdata = {1'b0, w_result};

endmodule

// File: verif/ook_pulse_width_decoder_unit_tb.sv
// Self-checking testbench for the pulse-width remote-control decoder unit.
`timescale 1ns / 1ps

module ook_pulse_width_decoder_unit_tb;

    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [1:0]  i_cfg_idx     = ookpw_pkg::CFG_SYNC_TH;
    logic [7:0]  i_cfg_data    = 8'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;               // [0] level, [7:1] zero
    logic [1:0]  s_axis_tuser  = ookpw_pkg::CMD_NOP; // [1:0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;            // [31:0] read_data, [32] frame_latched,
                                          // [38:33] bits_received, [39] zero

    ook_pulse_width_decoder_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Decoder settings as last written
    logic [7:0]                    th_sync;
    logic [7:0]                    th_long;
    logic [ookpw_pkg::COUNT_W-1:0] frame_min;
    logic [ookpw_pkg::COUNT_W-1:0] frame_max;

    // Decoder state mirrored by the predictor
    logic [ookpw_pkg::TIMER_W-1:0] gap_count;
    logic                          gap_running;
    logic [ookpw_pkg::TIMER_W-1:0] mark_len;
    logic [ookpw_pkg::WORD_W-1:0]  rx_word;
    logic [ookpw_pkg::COUNT_W-1:0] rx_bits;
    logic                          rx_broken;
    logic [ookpw_pkg::WORD_W-1:0]  held_frame;

    ookpw_pkg::t_result awaited_decodes[$];
    int      fault_count = 0;
    int      items_sent  = 0;
    int      burst_left  = 0;
    int      cycle_count = 0;

    logic [15:0] ready_pattern = 16'hFFFF;
    logic [3:0]  ready_phase   = 4'd0;

    // Restore the decoder state and settings to their reset values
    function automatic void reset_decoder_state();
        th_sync     = ookpw_pkg::RST_SYNC_TH;
        th_long     = ookpw_pkg::RST_LONG_TH;
        frame_min   = ookpw_pkg::RST_MIN_BITS;
        frame_max   = ookpw_pkg::RST_MAX_BITS;
        gap_count   = '0;
        gap_running = 1'b0;
        mark_len    = '0;
        rx_word     = '0;
        rx_bits     = '0;
        rx_broken   = 1'b1;
        held_frame  = '0;
    endfunction

    // Advance the decoder state by one command and return the report it yields
    function automatic ookpw_pkg::t_result decode_item(input logic [1:0] cmd,
                                                       input logic level);
        ookpw_pkg::t_result            rep;
        logic [ookpw_pkg::TIMER_W-1:0] elapsed;
        logic [ookpw_pkg::COUNT_W-1:0] limit;
        logic                          high_long;
        logic                          low_long;
        rep   = '0;
        limit = (frame_max > ookpw_pkg::WORD_BITS) ? ookpw_pkg::WORD_BITS : frame_max;
        case (cmd)
            ookpw_pkg::CMD_TICK: begin
                if (gap_running) begin
                    if (gap_count == ookpw_pkg::TIMER_TOP) begin
                        gap_count   = '0;
                        gap_running = 1'b0;
                    end else begin
                        gap_count = gap_count + 8'd1;
                    end
                end
            end
            ookpw_pkg::CMD_PIN: begin
                elapsed     = gap_count;
                gap_count   = '0;
                gap_running = 1'b1;
                if (!level) begin
                    mark_len = elapsed;
                end else if (elapsed > th_sync) begin
                    // Sync gap: latch a valid frame of acceptable length, then restart
                    if (!rx_broken && rx_bits >= frame_min && rx_bits <= limit) begin
                        held_frame        = rx_word;
                        rep.frame_latched = 1'b1;
                    end
                    rx_word   = '0;
                    rx_bits   = '0;
                    rx_broken = 1'b0;
                end else if (!rx_broken && rx_bits < limit) begin
                    high_long = mark_len > th_long;
                    low_long  = elapsed > th_long;
                    if (high_long == low_long) begin
                        rx_broken = 1'b1;
                        rx_bits   = '0;
                    end else begin
                        rx_word = {rx_word[ookpw_pkg::WORD_W-2:0], high_long};
                        rx_bits = rx_bits + 6'd1;
                    end
                end
            end
            ookpw_pkg::CMD_READ: begin
                rep.read_data = held_frame;
                held_frame    = '0;
            end
            default: begin
            end
        endcase
        rep.bits_received = rx_bits;
        return rep;
    endfunction

    // Offer one transaction, idling between bursts, and record its report on acceptance
    task automatic send_item(input logic [1:0] cmd, input logic level);
        int gap;
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 8);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {7'd0, level};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        awaited_decodes.push_back(decode_item(cmd, level));
        burst_left = burst_left - 1;
        items_sent = items_sent + 1;
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_item(ookpw_pkg::CMD_TICK, 1'($urandom_range(0, 1)));
    endtask

    // High phase of hi ticks, falling edge, low phase of lo ticks, rising edge
    task automatic send_symbol(input int hi, input int lo);
        send_ticks(hi);
        send_item(ookpw_pkg::CMD_PIN, 1'b0);
        send_ticks(lo);
        send_item(ookpw_pkg::CMD_PIN, 1'b1);
    endtask

    // Hold the stream until every outstanding report has been taken
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (awaited_decodes.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Write all four registers on consecutive cycles; the block must be idle
    task automatic load_settings(input logic [7:0] sync_v, input logic [7:0] long_v,
                                 input logic [5:0] min_v, input logic [5:0] max_v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= ookpw_pkg::CFG_SYNC_TH;
        i_cfg_data <= sync_v;
        @(posedge i_clk);
        th_sync = sync_v;
        i_cfg_idx  <= ookpw_pkg::CFG_LONG_TH;
        i_cfg_data <= long_v;
        @(posedge i_clk);
        th_long = long_v;
        i_cfg_idx  <= ookpw_pkg::CFG_MIN_BITS;
        i_cfg_data <= {2'b00, min_v};
        @(posedge i_clk);
        frame_min = min_v;
        i_cfg_idx  <= ookpw_pkg::CFG_MAX_BITS;
        i_cfg_data <= {2'b00, max_v};
        @(posedge i_clk);
        frame_max = max_v;
        i_cfg_we <= 1'b0;
    endtask

    function automatic int short_len();
        return $urandom_range(0, th_long);
    endfunction

    function automatic int long_len();
        return $urandom_range(th_long + 1, th_sync);
    endfunction

    function automatic int sync_len();
        return $urandom_range(th_sync + 1, (th_sync > 251) ? 255 : th_sync + 4);
    endfunction

    // Reset settings: idle commands, a sync on an invalid frame, then a full 24-bit frame
    task automatic test_reset_defaults();
        logic [23:0] pattern;
        pattern = 24'hB4396E;
        send_item(ookpw_pkg::CMD_READ, 1'b1);
        send_item(ookpw_pkg::CMD_NOP, 1'b1);
        send_item(ookpw_pkg::CMD_TICK, 1'b0);
        send_item(ookpw_pkg::CMD_PIN, 1'b1);
        send_symbol(3, 25);
        for (int i = 23; i >= 0; i--) begin
            if (pattern[i])
                send_symbol(6, 0);
            else
                send_symbol(0, 6);
        end
        send_symbol(1, 25);
        send_item(ookpw_pkg::CMD_READ, 1'b0);
        send_item(ookpw_pkg::CMD_READ, 1'b0);
        drain_results();
    endtask

    // Timer runs out past its top count and stops at zero; the top threshold never syncs
    task automatic test_timer_wrap();
        send_item(ookpw_pkg::CMD_PIN, 1'b0);
        send_ticks(256);
        send_ticks(2);
        send_item(ookpw_pkg::CMD_PIN, 1'b1);
        drain_results();
        load_settings(8'd255, 8'd5, 6'd0, 6'd32);
        send_symbol(1, 30);
        send_item(ookpw_pkg::CMD_READ, 1'b0);
        drain_results();
    endtask

    // Bit classes, broken symbols, full frames and the latch window edges
    task automatic test_symbol_rules();
        load_settings(8'd3, 8'd1, 6'd2, 6'd3);
        send_item(ookpw_pkg::CMD_READ, 1'b0);
        send_symbol(0, 4);
        send_symbol(2, 0);
        send_symbol(0, 2);
        send_symbol(0, 4);
        send_item(ookpw_pkg::CMD_READ, 1'b0);
        // long-long then short-short both spoil the frame until the next sync
        send_symbol(2, 2);
        send_symbol(3, 1);
        send_symbol(0, 4);
        send_symbol(1, 1);
        send_symbol(0, 5);
        // extra bits past the limit are dropped
        send_symbol(3, 0);
        send_symbol(0, 3);
        send_symbol(2, 1);
        send_symbol(2, 2);
        send_symbol(0, 4);
        send_item(ookpw_pkg::CMD_READ, 1'b0);
        drain_results();

        // Empty frame latches as a zero word
        load_settings(8'd3, 8'd1, 6'd0, 6'd0);
        send_symbol(0, 4);
        send_symbol(0, 4);
        send_item(ookpw_pkg::CMD_READ, 1'b0);
        drain_results();

        // Minimum above maximum never latches
        load_settings(8'd3, 8'd1, 6'd3, 6'd2);
        send_symbol(0, 4);
        send_symbol(2, 0);
        send_symbol(0, 2);
        send_symbol(0, 4);
        send_item(ookpw_pkg::CMD_READ, 1'b0);
        drain_results();

        // Maximum above the word width behaves as the word width
        load_settings(8'd2, 8'd0, 6'd0, 6'd63);
        send_symbol(0, 3);
        for (int i = 0; i < 33; i++) begin
            if ($urandom_range(0, 1))
                send_symbol(1, 0);
            else
                send_symbol(0, $urandom_range(1, 2));
        end
        send_symbol(0, 3);
        send_item(ookpw_pkg::CMD_READ, 1'b0);
        drain_results();

        // Zero sync threshold and top long threshold: every nonzero gap syncs, every phase is short
        load_settings(8'd0, 8'd255, 6'd0, 6'd32);
        send_item(ookpw_pkg::CMD_PIN, 1'b0);
        send_item(ookpw_pkg::CMD_PIN, 1'b1);
        send_symbol(0, 1);
        send_symbol(1, 1);
        send_item(ookpw_pkg::CMD_READ, 1'b0);
        drain_results();
    endtask

    // One sync followed by a frame of random content, with noise and broken symbols
    task automatic send_random_frame();
        int   lim;
        int   nbits;
        int   break_at;
        logic one;
        logic both_long;
        lim = (frame_max > ookpw_pkg::WORD_BITS) ? ookpw_pkg::WORD_BITS : frame_max;
        if (lim >= frame_min && $urandom_range(0, 3) != 0)
            nbits = $urandom_range(frame_min, lim);
        else
            nbits = $urandom_range(0, lim + 2);
        break_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, nbits) : -1;
        send_symbol($urandom_range(0, 3), sync_len());
        if ($urandom_range(0, 1))
            send_item(ookpw_pkg::CMD_READ, 1'($urandom_range(0, 1)));
        for (int i = 0; i < nbits; i++) begin
            if ($urandom_range(0, 11) == 0)
                send_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
            if (i == break_at) begin
                both_long = $urandom_range(0, 1);
                if (both_long)
                    send_symbol(long_len(), long_len());
                else
                    send_symbol(short_len(), short_len());
            end else begin
                one = $urandom_range(0, 1);
                if (one)
                    send_symbol(long_len(), short_len());
                else
                    send_symbol(short_len(), long_len());
            end
        end
    endtask

    // Random frames over several settings, draining between phases
    task automatic test_random_frames();
        int   stop_at;
        int   phase_end;
        int   phase;
        int   sync_v;
        int   long_v;
        int   min_v;
        int   max_v;
        stop_at = items_sent + 200;
        phase   = 0;
        while (items_sent < stop_at) begin
            case (phase % 6)
                0: begin
                    sync_v = $urandom_range(3, 10);
                    long_v = 0;
                    min_v  = 0;
                    max_v  = 8;
                end
                1: begin
                    sync_v = $urandom_range(6, 20);
                    long_v = $urandom_range(1, sync_v - 1);
                    min_v  = $urandom_range(1, 6);
                    max_v  = $urandom_range(min_v, 10);
                end
                2: begin
                    sync_v = 4;
                    long_v = 1;
                    min_v  = 32;
                    max_v  = 32;
                end
                3: begin
                    sync_v = $urandom_range(3, 12);
                    long_v = $urandom_range(0, sync_v - 1);
                    min_v  = $urandom_range(4, 10);
                    max_v  = $urandom_range(0, min_v - 1);
                end
                4: begin
                    sync_v = 5;
                    long_v = 2;
                    min_v  = $urandom_range(0, 4);
                    max_v  = $urandom_range(33, 63);
                end
                default: begin
                    sync_v = $urandom_range(1, 40);
                    long_v = $urandom_range(0, sync_v - 1);
                    min_v  = $urandom_range(0, 32);
                    max_v  = $urandom_range(0, 32);
                end
            endcase
            load_settings(8'(sync_v), 8'(long_v), 6'(min_v), 6'(max_v));
            phase_end = items_sent + 40;
            while (items_sent < phase_end)
                send_random_frame();
            send_symbol(0, sync_len());
            send_item(ookpw_pkg::CMD_READ, 1'b0);
            drain_results();
            phase = phase + 1;
        end
    endtask

    // Compare one accepted report with the oldest outstanding prediction
    task automatic check_report(input ookpw_pkg::t_result got);
        ookpw_pkg::t_result want;
        if (awaited_decodes.size() == 0) begin
            if (fault_count < 10)
                $display("unexpected report: data %h latched %b bits %0d",
                         got.read_data, got.frame_latched, got.bits_received);
            fault_count = fault_count + 1;
        end else begin
            want = awaited_decodes.pop_front();
            if (got.read_data !== want.read_data || got.frame_latched !== want.frame_latched ||
                got.bits_received !== want.bits_received) begin
                if (fault_count < 10)
                    $display({"report mismatch: expected data %h latched %b bits %0d, ",
                              "got data %h latched %b bits %0d"},
                             want.read_data, want.frame_latched, want.bits_received,
                             got.read_data, got.frame_latched, got.bits_received);
                fault_count = fault_count + 1;
            end
        end
    endtask

    // Take reports and stall the output on a rotating pattern, reloaded each time the phase wraps
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            check_report(m_axis_tdata[38:0]);
        if (ready_phase == 4'd15) begin
            case ($urandom_range(0, 2))
                0: ready_pattern <= 16'hFFFF;
                1: ready_pattern <= 16'($urandom) | 16'h0001;
                default: ready_pattern <= 16'($urandom & $urandom) | 16'h0001;
            endcase
        end
        ready_phase   <= ready_phase + 1'b1;
        m_axis_tready <= ready_pattern[ready_phase];
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("ook_pulse_width_decoder_unit_tb: errors");
            $finish;
        end
    end

    initial begin
        reset_decoder_state();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_timer_wrap();
        test_symbol_rules();
        test_random_frames();

        drain_results();
        repeat (4) @(posedge i_clk);
        if (fault_count == 0 && awaited_decodes.size() == 0)
            $display("ook_pulse_width_decoder_unit_tb: clean");
        else
            $display("ook_pulse_width_decoder_unit_tb: errors");
        $finish;
    end

endmodule

// File: sim.f
hdl/ookpw_pkg.sv
hdl/ookpw_front.sv
hdl/ookpw_queue.sv
hdl/ookpw_back.sv
hdl/ook_pulse_width_decoder_unit.sv
verif/ook_pulse_width_decoder_unit_tb.sv
